/* hdl/assert_macros.svh */
// Assertion helpers for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, sampled on the rising clock edge, off during reset.
`define ANPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ANPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication.
`define ANPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* hdl/anpc_pkg.sv */
`default_nettype none

package anpc_pkg;

	// NAL header fields
	localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
	localparam logic [4:0] NAL_TYPE_IDR       = 5'd5;
	localparam logic [4:0] NAL_TYPE_SLICE_MAX = 5'd4;
	localparam logic [4:0] NAL_TYPE_LOW_MAX   = 5'd16;
	localparam logic [4:0] NAL_TYPE_HIGH_MIN  = 5'd19;
	localparam logic [4:0] NAL_TYPE_HIGH_MAX  = 5'd21;

	// Smallest legal NAL length (header byte plus one)
	localparam logic [31:0] NAL_LEN_MIN = 32'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       key_pic;
	} pkt_item_t;

	typedef struct packed {
		logic accepted;
		logic saw_idr;
		logic saw_non_idr_slice;
	} verdict_t;

	// Step request from the top level to the parser core
	typedef struct packed {
		logic      step;
		pkt_item_t item;
	} core_req_t;

	function automatic logic header_ok(input logic [7:0] hdr);
		logic [4:0] t;
		t = hdr[4:0];
		if ((hdr & HDR_FORBIDDEN_MASK) != 8'h00) begin
			return 1'b0;
		end
		return ((t != 5'd0) && (t <= NAL_TYPE_LOW_MAX)) ||
			((t >= NAL_TYPE_HIGH_MIN) && (t <= NAL_TYPE_HIGH_MAX));
	endfunction

endpackage

`default_nettype wire

/* hdl/anpc_stream_if.sv */
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface anpc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/avcc_nal_packet_checker.sv */
`default_nettype none

// AVCC access-unit checker. Packet bytes enter on pkt, one byte per transaction, with
// the final byte flagged by last_byte and the frame kind read from key_pic on that
// byte. One verdict transaction leaves on verdict for each packet, nothing for other
// bytes. Throughput is one byte per clock; a byte is registered on entry in the input
// register, and the verdict of a last byte is registered in the result register as that
// byte leaves the input register, and is offered from there. The per-byte step is a 32-bit
// prefix shift, a 32-bit length decrement with a zero compare and the header type
// decode, all combinational from the input register. Input stalls only when a last byte
// waits in the input register behind an unread verdict.
module avcc_nal_packet_checker import anpc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	anpc_stream_if.sink   pkt,
	anpc_stream_if.source verdict
);

	logic      valid_s1;
	pkt_item_t item_s1;
	logic      out_valid_q;
	verdict_t  out_q;
	logic      out_free;
	logic      adv_s1;
	core_req_t core_req;
	verdict_t  core_result;

	// Stage 1 advances unless it holds a last byte and the result register is full and not being read
	assign out_free  = !out_valid_q || verdict.ready;
	assign adv_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign pkt.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			item_s1 <= pkt.data;
		end
	end

	assign core_req.step = adv_s1;
	assign core_req.item = item_s1;

	anpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (core_req),
		.result (core_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_byte) begin
			out_q <= core_result;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.data  = out_q;

endmodule

`default_nettype wire

/* hdl/anpc_core.sv */
`default_nettype none

// Per-packet parse state and the single-byte step logic.
module anpc_core import anpc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_req_t req,
	output verdict_t       result
);

	logic [1:0]  prefix_index_q;
	logic [31:0] length_shift_q;
	logic [31:0] bytes_left_q;
	logic        in_nal_body_q;
	logic        header_pending_q;
	logic        error_seen_q;
	logic        idr_flag_q;
	logic        non_idr_flag_q;

	logic [1:0]  prefix_index_d;
	logic [31:0] length_shift_d;
	logic [31:0] bytes_left_d;
	logic        in_nal_body_d;
	logic        header_pending_d;
	logic        error_seen_d;
	logic        idr_flag_d;
	logic        non_idr_flag_d;

	logic [7:0]  b;
	logic [4:0]  unit_type;
	logic        boundary;
	logic        kind_ok;

	assign b         = req.item.data_byte;
	assign unit_type = b[4:0];

	// Next state for one byte
	always_comb begin
		prefix_index_d   = prefix_index_q;
		length_shift_d   = length_shift_q;
		bytes_left_d     = bytes_left_q;
		in_nal_body_d    = in_nal_body_q;
		header_pending_d = header_pending_q;
		error_seen_d     = error_seen_q;
		idr_flag_d       = idr_flag_q;
		non_idr_flag_d   = non_idr_flag_q;

		if (!error_seen_q) begin
			if (!in_nal_body_q) begin
				// length prefix, big-endian
				length_shift_d = {length_shift_q[23:0], b};
				prefix_index_d = prefix_index_q + 2'd1;
				if (prefix_index_d == 2'd0) begin
					if (length_shift_d < NAL_LEN_MIN) begin
						error_seen_d = 1'b1;
					end else begin
						bytes_left_d     = length_shift_d;
						in_nal_body_d    = 1'b1;
						header_pending_d = 1'b1;
					end
					length_shift_d = '0;
				end
			end else begin
				if (header_pending_q) begin
					header_pending_d = 1'b0;
					if (!header_ok(b)) begin
						error_seen_d = 1'b1;
					end else begin
						if (unit_type == NAL_TYPE_IDR) begin
							idr_flag_d = 1'b1;
						end
						if ((unit_type != 5'd0) && (unit_type <= NAL_TYPE_SLICE_MAX)) begin
							non_idr_flag_d = 1'b1;
						end
					end
				end
				// body byte count
				if (!error_seen_d) begin
					bytes_left_d = bytes_left_q - 32'd1;
					if (bytes_left_d == 32'd0) begin
						in_nal_body_d = 1'b0;
					end
				end
			end
		end
	end

	// Verdict from the state after this byte
	always_comb begin
		boundary = !in_nal_body_d && (prefix_index_d == 2'd0);
		kind_ok  = req.item.key_pic ? (idr_flag_d && !non_idr_flag_d)
			: (non_idr_flag_d && !idr_flag_d);
		result.accepted          = !error_seen_d && boundary && kind_ok;
		result.saw_idr           = idr_flag_d;
		result.saw_non_idr_slice = non_idr_flag_d;
	end

	// State registers; the last byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_index_q   <= '0;
			length_shift_q   <= '0;
			bytes_left_q     <= '0;
			in_nal_body_q    <= 1'b0;
			header_pending_q <= 1'b0;
			error_seen_q     <= 1'b0;
			idr_flag_q       <= 1'b0;
			non_idr_flag_q   <= 1'b0;
		end else if (req.step) begin
			if (req.item.last_byte) begin
				prefix_index_q   <= '0;
				length_shift_q   <= '0;
				bytes_left_q     <= '0;
				in_nal_body_q    <= 1'b0;
				header_pending_q <= 1'b0;
				error_seen_q     <= 1'b0;
				idr_flag_q       <= 1'b0;
				non_idr_flag_q   <= 1'b0;
			end else begin
				prefix_index_q   <= prefix_index_d;
				length_shift_q   <= length_shift_d;
				bytes_left_q     <= bytes_left_d;
				in_nal_body_q    <= in_nal_body_d;
				header_pending_q <= header_pending_d;
				error_seen_q     <= error_seen_d;
				idr_flag_q       <= idr_flag_d;
				non_idr_flag_q   <= non_idr_flag_d;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/anpc_checker.sv */
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the packet checker.
module anpc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pkt_valid,
	input wire logic pkt_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_accepted,
	input wire logic out_saw_idr,
	input wire logic out_saw_non_idr
);

	// A pending verdict holds until its transaction completes
	`ANPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({out_accepted, out_saw_idr, out_saw_non_idr}))

	// A passing packet saw exactly one slice kind
	`ANPC_ASSERT_IMP(a_pass_one_kind, clk, arst_n, out_valid && out_accepted, out_saw_idr != out_saw_non_idr)

	// Input only stalls behind an unread verdict
	`ANPC_ASSERT_IMP(a_stall_cause, clk, arst_n, !pkt_ready, out_valid && !out_ready)

	// Once the verdict is taken, input cannot stall in the next cycle unless a new verdict is pending
	`ANPC_ASSERT_NXT(a_no_stall_after_take, clk, arst_n, out_valid && out_ready && pkt_valid, pkt_ready || out_valid)

endmodule

bind avcc_nal_packet_checker anpc_checker u_anpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pkt_valid       (pkt.valid),
	.pkt_ready       (pkt.ready),
	.out_valid       (verdict.valid),
	.out_ready       (verdict.ready),
	.out_accepted    (verdict.data.accepted),
	.out_saw_idr     (verdict.data.saw_idr),
	.out_saw_non_idr (verdict.data.saw_non_idr_slice)
);

`default_nettype wire
